// ===== sv/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// Jacobi Poisson sweep package
// Shared constants, register indices and state encodings for the sweep block.
// ----------------------------------------------------------------------------
package jps_pkg;

  localparam int MAX_COLS_DEF   = 4096;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ROW_BITS       = 16;
  localparam int COLCNT_BITS    = 13;
  localparam int ECOL_BITS      = 14;
  localparam int AREA_BITS      = 40;
  localparam int AREA_FRAC      = 40;
  localparam int SUM_BITS       = 64;
  localparam int SQ_SHIFT       = 16;
  localparam int MIN_DIM        = 3;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 40;

  localparam logic [ROW_BITS-1:0]    ROW_COUNT_RST = ROW_BITS'(2048);
  localparam logic [COLCNT_BITS-1:0] COL_COUNT_RST = COLCNT_BITS'(2048);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ROW_COUNT = 2'd0,
    CFG_COL_COUNT = 2'd1,
    CFG_STEP_AREA = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RIGHT,
    ST_SRC_WAIT,
    ST_SUM,
    ST_SQ1,
    ST_SQ1_WAIT,
    ST_SQ2,
    ST_SQ2_WAIT
  } jps_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SUM
  } mul_phase_e;

endpackage

// ===== sv/jps_ram.sv =====
// ----------------------------------------------------------------------------
// Generic line store
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/jps_mul.sv =====
// ----------------------------------------------------------------------------
// Two-pass unsigned multiplier
// Forms a times b as two half-width partial products and one final add.
// ----------------------------------------------------------------------------
module jps_mul #(
  parameter int AW = 32,
  parameter int BW = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output logic [AW+BW-1:0] prod_o,
  output logic           valid_o
);
  import jps_pkg::*;

  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  mul_phase_e        phase_q, phase_d;
  logic              valid_q, valid_d;
  logic [AW-1:0]     a_q;
  logic [BW-1:0]     b_q;
  logic [AW+BL-1:0]  pp_lo_q;
  logic [AW+BH-1:0]  pp_hi_q;
  logic [PW-1:0]     prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MUL_IDLE;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    if (start_i) begin
      phase_d = MUL_LO;
      valid_d = 1'b0;
    end else begin
      case (phase_q)
        MUL_IDLE: phase_d = MUL_IDLE;
        MUL_LO:   phase_d = MUL_HI;
        MUL_HI:   phase_d = MUL_SUM;
        MUL_SUM: begin
          phase_d = MUL_IDLE;
          valid_d = 1'b1;
        end
        default:  phase_d = MUL_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (phase_q == MUL_LO) begin
      pp_lo_q <= (AW+BL)'(a_q) * (AW+BL)'(b_q[BL-1:0]);
    end
    if (phase_q == MUL_HI) begin
      pp_hi_q <= (AW+BH)'(a_q) * (AW+BH)'(b_q[BW-1:BL]);
    end
    if (phase_q == MUL_SUM) begin
      prod_q <= (PW'(pp_hi_q) << BL) + PW'(pp_lo_q);
    end
  end

  assign prod_o  = prod_q;
  assign valid_o = valid_q;

endmodule

// ===== sv/jacobi_poisson_stencil_sweep_top.sv =====
// ----------------------------------------------------------------------------
// Jacobi Poisson stencil sweep: one request occupies the block until it is finished. After
// the line store reads, the shared two-pass multiplier forms the source term (inner points)
// and a squared difference, plus a second one on the last row for the request's own point.
// Reset is asynchronous; the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module jacobi_poisson_stencil_sweep_top #(
  parameter int MAX_COLS   = jps_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = jps_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jps_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [jps_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [VALUE_BITS-1:0]        u_value_i,
  input  logic signed [VALUE_BITS-1:0]        f_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [VALUE_BITS-1:0]        unew_value_o,
  output logic [jps_pkg::ROW_BITS-1:0]        out_row_o,
  output logic [$clog2(MAX_COLS)-1:0]         out_col_o,
  output logic                                grid_done_o,
  output logic [jps_pkg::SUM_BITS-1:0]        diff_sum_sq_o
);
  import jps_pkg::*;

  localparam int VB  = VALUE_BITS;
  localparam int CW  = $clog2(MAX_COLS);
  localparam int MBW = (VB > AREA_BITS) ? VB : AREA_BITS;
  localparam int PW  = VB + MBW;
  localparam int SQW = (PW > SUM_BITS + SQ_SHIFT) ? PW : SUM_BITS + SQ_SHIFT + 1;

  // Configuration registers.
  logic [ROW_BITS-1:0]    row_count_q;
  logic [COLCNT_BITS-1:0] col_count_q;
  logic [AREA_BITS-1:0]   step_area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
      step_area_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT: row_count_q <= cfg_wdata_i[ROW_BITS-1:0];
        CFG_COL_COUNT: col_count_q <= cfg_wdata_i[COLCNT_BITS-1:0];
        CFG_STEP_AREA: step_area_q <= cfg_wdata_i[AREA_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  jps_state_e          state_q, state_d;
  logic [ROW_BITS-1:0] row_pos_q;
  logic [CW-1:0]       col_pos_q;
  logic [SUM_BITS-1:0] acc_q;
  logic signed [VB-1:0] left_q;
  logic                out_valid_q;

  // Request and working registers.
  logic signed [VB-1:0] u_q, f_q, above_q, older_q, fr_q, v_q;
  logic signed [VB+1:0] sum4_q;
  logic signed [VB:0]   term_q;
  logic [ROW_BITS-1:0]  r_q;
  logic [CW-1:0]        c_q;
  logic                 top_q, first_row_q, col_edge_q, last_row_q, last_col_q;

  // Output register.
  logic signed [VB-1:0] unew_q;
  logic [ROW_BITS-1:0]  orow_q;
  logic [CW-1:0]        ocol_q;
  logic                 done_q;
  logic [SUM_BITS-1:0]  dsum_q;

  // Effective bounds and the position of the next request.
  logic [ROW_BITS-1:0]  erows, r_now;
  logic [ECOL_BITS-1:0] ecols, col_ext;
  logic [CW-1:0]        c_now;

  always_comb begin
    erows = (row_count_q < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : row_count_q;
    col_ext = ECOL_BITS'(col_count_q);
    if (col_ext < ECOL_BITS'(MIN_DIM)) begin
      ecols = ECOL_BITS'(MIN_DIM);
    end else if (col_ext > ECOL_BITS'(MAX_COLS)) begin
      ecols = ECOL_BITS'(MAX_COLS);
    end else begin
      ecols = col_ext;
    end
    r_now = (row_pos_q >= erows) ? '0 : row_pos_q;
    c_now = (ECOL_BITS'(col_pos_q) >= ecols) ? '0 : col_pos_q;
  end

  // Line stores.
  logic          ram_we;
  logic [CW-1:0] recent_raddr;
  logic [VB-1:0] recent_rd, older_rd, frec_rd;

  assign recent_raddr = (state_q == ST_READ) ? c_q + CW'(1) : c_now;

  jps_ram #(.WIDTH(VB), .DEPTH(MAX_COLS)) u_recent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (u_q),
    .raddr_i (recent_raddr),
    .rdata_o (recent_rd)
  );

  jps_ram #(.WIDTH(VB), .DEPTH(MAX_COLS)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (recent_rd),
    .raddr_i (c_now),
    .rdata_o (older_rd)
  );

  jps_ram #(.WIDTH(VB), .DEPTH(MAX_COLS)) f_recent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (f_q),
    .raddr_i (c_now),
    .rdata_o (frec_rd)
  );

  // Shared multiplier: source term in one pass, squared differences in others.
  logic            mul_start, mul_valid;
  logic [VB-1:0]   mul_a, fr_mag, d_mag;
  logic [MBW-1:0]  mul_b;
  logic [PW-1:0]   prod;
  logic signed [VB:0] d, d_neg;

  always_comb begin
    fr_mag = fr_q[VB-1] ? (~fr_q + 1'b1) : fr_q;
    if (state_q == ST_SQ2) begin
      d = (VB+1)'(f_q) - (VB+1)'(u_q);
    end else begin
      d = (VB+1)'(v_q) - (VB+1)'(above_q);
    end
    d_neg = -d;
    d_mag = d[VB] ? d_neg[VB-1:0] : d[VB-1:0];
    if (state_q == ST_RIGHT) begin
      mul_a = fr_mag;
      mul_b = MBW'(step_area_q);
    end else begin
      mul_a = d_mag;
      mul_b = MBW'(d_mag);
    end
  end

  jps_mul #(.AW(VB), .BW(MBW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .valid_o (mul_valid)
  );

  // Source term, stencil sum and rounding.
  logic [VB-1:0]        q;
  logic                 rem;
  logic signed [VB:0]   term;
  logic signed [VB+1:0] sum4;
  logic signed [VB+2:0] sum5;
  logic signed [VB:0]   shr;
  logic signed [VB-1:0] v_sum;

  always_comb begin
    q    = prod[AREA_FRAC +: VB];
    rem  = |prod[AREA_FRAC-1:0];
    if (fr_q[VB-1]) begin
      term = -$signed({1'b0, q}) - $signed({{VB{1'b0}}, rem});
    end else begin
      term = $signed({1'b0, q});
    end
    sum4 = (VB+2)'(older_q) + (VB+2)'(u_q) + (VB+2)'(left_q)
         + (VB+2)'($signed(recent_rd));
    sum5 = (VB+3)'(sum4_q) + (VB+3)'(term_q) + (VB+3)'(2);
    shr  = sum5[VB+2:2];
    if (shr[VB] != shr[VB-1]) begin
      v_sum = shr[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end else begin
      v_sum = shr[VB-1:0];
    end
  end

  // Squared difference and saturating accumulation.
  logic [SQW-1:0]      sq_ext;
  logic [SUM_BITS-1:0] sq64, acc_new;
  logic [SUM_BITS:0]   acc_sum;

  always_comb begin
    sq_ext  = SQW'(prod);
    sq64    = (|sq_ext[SQW-1:SUM_BITS+SQ_SHIFT]) ? '1 : sq_ext[SUM_BITS+SQ_SHIFT-1:SQ_SHIFT];
    acc_sum = {1'b0, acc_q} + {1'b0, sq64};
    acc_new = acc_sum[SUM_BITS] ? '1 : acc_sum[SUM_BITS-1:0];
  end

  // Sequencer.
  logic in_accept, out_free, out_load, res_last, finish;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    res_last  = 1'b0;
    finish    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_we  = 1'b1;
        state_d = ST_RIGHT;
      end
      ST_RIGHT: begin
        if (!top_q) begin
          if (last_row_q) begin
            state_d = ST_SQ2;
          end else begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (first_row_q || col_edge_q) begin
          state_d = ST_SQ1;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_SRC_WAIT;
        end
      end
      ST_SRC_WAIT: begin
        if (mul_valid) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: state_d = ST_SQ1;
      ST_SQ1: begin
        mul_start = 1'b1;
        state_d   = ST_SQ1_WAIT;
      end
      ST_SQ1_WAIT: begin
        if (mul_valid && out_free) begin
          out_load = 1'b1;
          if (last_row_q) begin
            state_d = ST_SQ2;
          end else begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_SQ2: begin
        mul_start = 1'b1;
        state_d   = ST_SQ2_WAIT;
      end
      ST_SQ2_WAIT: begin
        if (mul_valid && out_free) begin
          out_load = 1'b1;
          res_last = 1'b1;
          finish   = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q   <= '0;
      col_pos_q   <= '0;
      acc_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        left_q <= above_q;
        if (last_col_q) begin
          col_pos_q <= '0;
          row_pos_q <= last_row_q ? '0 : r_q + ROW_BITS'(1);
        end else begin
          col_pos_q <= c_q + CW'(1);
        end
      end
      if (out_load) begin
        acc_q <= (res_last && last_col_q) ? '0 : acc_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      u_q         <= u_value_i;
      f_q         <= f_value_i;
      r_q         <= r_now;
      c_q         <= c_now;
      top_q       <= (r_now != '0);
      first_row_q <= (r_now == ROW_BITS'(1));
      last_row_q  <= (r_now == erows - ROW_BITS'(1));
      last_col_q  <= (ECOL_BITS'(c_now) == ecols - ECOL_BITS'(1));
      col_edge_q  <= (c_now == '0) || (ECOL_BITS'(c_now) == ecols - ECOL_BITS'(1));
    end
    if (state_q == ST_READ) begin
      above_q <= recent_rd;
      older_q <= older_rd;
      fr_q    <= frec_rd;
    end
    if (state_q == ST_RIGHT) begin
      sum4_q <= sum4;
      v_q    <= fr_q;
    end
    if (state_q == ST_SRC_WAIT && mul_valid) begin
      term_q <= term;
    end
    if (state_q == ST_SUM) begin
      v_q <= v_sum;
    end
    if (out_load) begin
      ocol_q <= c_q;
      if (res_last) begin
        unew_q <= f_q;
        orow_q <= r_q;
        done_q <= last_col_q;
        dsum_q <= last_col_q ? acc_new : '0;
      end else begin
        unew_q <= v_q;
        orow_q <= r_q - ROW_BITS'(1);
        done_q <= 1'b0;
        dsum_q <= '0;
      end
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign unew_value_o  = unew_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign grid_done_o   = done_q;
  assign diff_sum_sq_o = dsum_q;

`ifndef ASSERT_OFF
  a_sum_only_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grid_done_o |-> diff_sum_sq_o == '0)
    else $error("Difference sum shown on a result that does not end the grid.");

  a_done_at_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grid_done_o |->
      (ECOL_BITS'(out_col_o) == ecols - ECOL_BITS'(1)) && (out_row_o == erows - ROW_BITS'(1)))
    else $error("Grid completion flagged away from the final point.");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_last && last_col_q |=> acc_q == '0)
    else $error("Accumulator not cleared after the final point of the grid.");
`endif

endmodule

// ===== sim/jacobi_poisson_stencil_sweep_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Jacobi Poisson stencil sweep testbench
// Streams grids of (u, f) requests through the sweep block, with random gaps
// on the request side and random stalls on the result side. A bit-true model
// of the line stores, the stencil and the squared-difference sum is kept
// here, and every emitted point is compared with it field by field. The run
// covers small and wide grids, saturation, bounds that move in mid-sweep and
// random sweeps.
// ----------------------------------------------------------------------------
module jacobi_poisson_stencil_sweep_top_test;
  import jps_pkg::*;

  localparam int COLS           = 4096;
  localparam int VBITS          = 32;
  localparam int COL_BITS       = $clog2(COLS);
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_POINTS  = 300;
  localparam int WIDE_POINTS    = 40;

  localparam logic signed [63:0] VALUE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] VALUE_MIN = -64'sd2147483648;
  localparam logic signed [VBITS-1:0] U_MAX = 32'sh7FFFFFFF;
  localparam logic signed [VBITS-1:0] U_MIN = 32'sh80000000;

  typedef enum int {
    VALUES_FULL,
    VALUES_SMALL,
    VALUES_EXTREME
  } value_mode_e;

  typedef struct packed {
    logic signed [VBITS-1:0] unew;
    logic [ROW_BITS-1:0]     row;
    logic [COL_BITS-1:0]     col;
    logic                    done;
    logic [SUM_BITS-1:0]     sum;
  } sweep_point_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_INDEX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [VBITS-1:0]    u_value_i   = '0;
  logic signed [VBITS-1:0]    f_value_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [VBITS-1:0]    unew_value_o;
  logic [ROW_BITS-1:0]        out_row_o;
  logic [COL_BITS-1:0]        out_col_o;
  logic                       grid_done_o;
  logic [SUM_BITS-1:0]        diff_sum_sq_o;

  jacobi_poisson_stencil_sweep_top #(
    .MAX_COLS   (COLS),
    .VALUE_BITS (VBITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .u_value_i     (u_value_i),
    .f_value_i     (f_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .unew_value_o  (unew_value_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .grid_done_o   (grid_done_o),
    .diff_sum_sq_o (diff_sum_sq_o)
  );

  logic signed [VBITS-1:0] u_older_mem  [COLS];
  logic signed [VBITS-1:0] u_recent_mem [COLS];
  logic signed [VBITS-1:0] f_recent_mem [COLS];
  logic signed [VBITS-1:0] left_u_q = '0;
  logic [ROW_BITS-1:0]     row_pos_q = '0;
  logic [COL_BITS-1:0]     col_pos_q = '0;
  logic [SUM_BITS-1:0]     diff_acc_q = '0;
  logic [ROW_BITS-1:0]     row_count_q = ROW_COUNT_RST;
  logic [COLCNT_BITS-1:0]  col_count_q = COL_COUNT_RST;
  logic [AREA_BITS-1:0]    step_area_q = '0;

  sweep_point_t pending_points[$];
  bit           sweep_closed   = 1'b0;
  bit           no_gaps        = 1'b0;
  int           mismatch_count = 0;
  int           points_sent    = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int grid_rows();
    return (row_count_q < MIN_DIM) ? MIN_DIM : int'(row_count_q);
  endfunction

  function automatic int grid_cols();
    int n;
    n = (col_count_q < MIN_DIM) ? MIN_DIM : int'(col_count_q);
    return (n > COLS) ? COLS : n;
  endfunction

  function automatic logic signed [VBITS-1:0] stencil_value(
    input logic signed [VBITS-1:0] up,
    input logic signed [VBITS-1:0] down,
    input logic signed [VBITS-1:0] left_n,
    input logic signed [VBITS-1:0] right_n,
    input logic signed [VBITS-1:0] src_f
  );
    logic signed [79:0] prod;
    logic signed [63:0] total;
    prod  = 80'(src_f) * $signed({40'd0, step_area_q});
    total = 64'(up) + 64'(down) + 64'(left_n) + 64'(right_n) + 64'(prod >>> AREA_FRAC);
    total = (total + 64'sd2) >>> 2;
    if (total > VALUE_MAX) total = VALUE_MAX;
    else if (total < VALUE_MIN) total = VALUE_MIN;
    return total[VBITS-1:0];
  endfunction

  function automatic void add_square_diff(input logic signed [VBITS-1:0] a,
                                          input logic signed [VBITS-1:0] b);
    logic signed [VBITS:0] diff;
    logic [VBITS:0]        mag;
    logic [127:0]          sq_full;
    logic [SUM_BITS-1:0]   sq;
    logic [SUM_BITS:0]     total;
    diff    = a - b;
    mag     = diff[VBITS] ? -diff : diff;
    sq_full = mag * mag;
    sq      = (sq_full[127:SUM_BITS+SQ_SHIFT] != 0) ? '1
                                                   : sq_full[SUM_BITS+SQ_SHIFT-1:SQ_SHIFT];
    total      = diff_acc_q + sq;
    diff_acc_q = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
  endfunction

  // Takes one accepted request into the line stores and queues the points
  // that it completes: the point above it, and itself on the last row.
  task automatic advance_sweep(input logic signed [VBITS-1:0] u_in,
                               input logic signed [VBITS-1:0] f_in);
    int                      erows;
    int                      ecols;
    int                      r;
    int                      c;
    logic signed [VBITS-1:0] above_old;
    logic signed [VBITS-1:0] unew;
    sweep_point_t            pt;
    erows = grid_rows();
    ecols = grid_cols();
    if (row_pos_q >= erows) row_pos_q = '0;
    if (col_pos_q >= ecols) col_pos_q = '0;
    r = row_pos_q;
    c = col_pos_q;
    above_old = u_recent_mem[c];
    sweep_closed = 1'b0;

    if (r >= 1) begin
      if (r == 1 || c == 0 || c == ecols - 1) begin
        unew = f_recent_mem[c];
      end else begin
        unew = stencil_value(u_older_mem[c], u_in, left_u_q, u_recent_mem[c+1],
                             f_recent_mem[c]);
      end
      add_square_diff(unew, above_old);
      pt.unew = unew;
      pt.row  = ROW_BITS'(r - 1);
      pt.col  = COL_BITS'(c);
      pt.done = 1'b0;
      pt.sum  = '0;
      pending_points.push_back(pt);
    end
    if (r == erows - 1) begin
      add_square_diff(f_in, u_in);
      pt.unew = f_in;
      pt.row  = ROW_BITS'(r);
      pt.col  = COL_BITS'(c);
      pt.done = (c == ecols - 1);
      pt.sum  = pt.done ? diff_acc_q : '0;
      pending_points.push_back(pt);
      if (pt.done) begin
        diff_acc_q   = '0;
        sweep_closed = 1'b1;
      end
    end

    left_u_q        = above_old;
    u_older_mem[c]  = above_old;
    u_recent_mem[c] = u_in;
    f_recent_mem[c] = f_in;
    if (c + 1 >= ecols) begin
      col_pos_q = '0;
      row_pos_q = (r + 1 >= erows) ? '0 : ROW_BITS'(r + 1);
    end else begin
      col_pos_q = COL_BITS'(c + 1);
    end
  endtask

  function automatic logic signed [VBITS-1:0] random_value(input value_mode_e mode);
    logic [31:0] raw;
    raw = $urandom;
    case (mode)
      VALUES_SMALL: return {{12{raw[19]}}, raw[19:0]};
      VALUES_EXTREME: begin
        case (raw[2:0])
          3'd0:    return U_MAX;
          3'd1:    return U_MIN;
          3'd2:    return '0;
          3'd3:    return '1;
          default: return $urandom;
        endcase
      end
      default: return raw;
    endcase
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROW_COUNT: row_count_q = data[ROW_BITS-1:0];
      CFG_COL_COUNT: col_count_q = data[COLCNT_BITS-1:0];
      CFG_STEP_AREA: step_area_q = data[AREA_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_point(input logic signed [VBITS-1:0] u, input logic signed [VBITS-1:0] f);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(15, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    u_value_i  <= u;
    f_value_i  <= f;
    do @(posedge clk_i); while (in_stall_o);
    advance_sweep(u, f);
    points_sent++;
  endtask

  task automatic finish_sweep(input value_mode_e mode);
    do send_point(random_value(mode), random_value(mode)); while (!sweep_closed);
  endtask

  // Lets the block run dry so that its registers may be rewritten.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_edge_saturation();
    no_gaps = 1'b0;
    write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(2));
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(1));
    write_reg(CFG_STEP_AREA, {CFG_DATA_BITS{1'b1}});
    repeat (9) send_point(U_MAX, U_MAX);
    quiesce();
    write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(3));
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(4));
    for (int k = 0; k < 12; k++) begin
      send_point(U_MIN, (k >= 8 && k[0]) ? U_MAX : U_MIN);
    end
    quiesce();
  endtask

  task automatic test_wide_grid();
    write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(3));
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(8191));
    write_reg(CFG_STEP_AREA, '0);
    repeat (WIDE_POINTS) send_point(random_value(VALUES_FULL), random_value(VALUES_FULL));
    quiesce();
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(3));
    finish_sweep(VALUES_FULL);
    quiesce();
  endtask

  task automatic test_moved_bounds();
    write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(65535));
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(4096));
    write_reg(CFG_STEP_AREA, CFG_DATA_BITS'({$urandom, $urandom}));
    repeat (7) send_point(random_value(VALUES_FULL), random_value(VALUES_FULL));
    quiesce();
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(5));
    repeat (14) send_point(random_value(VALUES_SMALL), random_value(VALUES_SMALL));
    quiesce();
    write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(3));
    repeat (6) send_point(random_value(VALUES_FULL), random_value(VALUES_FULL));
    quiesce();
    write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(4));
    finish_sweep(VALUES_FULL);
    quiesce();
  endtask

  task automatic test_random_sweeps();
    int          start;
    int          dim;
    int          size;
    int          partial;
    int          which;
    value_mode_e mode;
    start = points_sent;
    while (points_sent - start < RANDOM_POINTS) begin
      no_gaps = ($urandom_range(3, 0) == 0);
      mode    = value_mode_e'($urandom_range(2, 0));
      if ($urandom_range(3, 0) != 0) begin
        case ($urandom_range(19, 0))
          0:       dim = 65535;
          1:       dim = $urandom_range(65535, 0);
          2, 3, 4: dim = $urandom_range(24, 7);
          default: dim = $urandom_range(6, 0);
        endcase
        write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'(dim));
      end
      if ($urandom_range(3, 0) != 0) begin
        case ($urandom_range(19, 0))
          0:       dim = $urandom_range(1, 0) ? 4096 : 8191;
          1:       dim = $urandom_range(8191, 0);
          2, 3, 4: dim = $urandom_range(40, 9);
          default: dim = $urandom_range(8, 0);
        endcase
        write_reg(CFG_COL_COUNT, CFG_DATA_BITS'(dim));
      end
      if ($urandom_range(1, 0) != 0) begin
        case ($urandom_range(7, 0))
          0:       write_reg(CFG_STEP_AREA, '0);
          1:       write_reg(CFG_STEP_AREA, {CFG_DATA_BITS{1'b1}});
          default: write_reg(CFG_STEP_AREA, CFG_DATA_BITS'({$urandom, $urandom}));
        endcase
      end

      size = grid_rows() * grid_cols();
      if (size > 300 || $urandom_range(4, 0) == 0) begin
        partial = $urandom_range((size - 1 < 60) ? size - 1 : 60, 1);
        repeat (partial) send_point(random_value(mode), random_value(mode));
        quiesce();
        which = (size > 300) ? 2 : $urandom_range(2, 0);
        if (which != 1) write_reg(CFG_ROW_COUNT, CFG_DATA_BITS'($urandom_range(6, 0)));
        if (which != 0) write_reg(CFG_COL_COUNT, CFG_DATA_BITS'($urandom_range(8, 0)));
      end
      finish_sweep(mode);
      quiesce();
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin : result_checker
    sweep_point_t want;
    int           hold;
    @(posedge rst_ni);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(15, 0);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_points.size() == 0) begin
        $error("unexpected point at row %0d, column %0d", out_row_o, out_col_o);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        check_field("unew_value", 64'(want.unew), 64'(unew_value_o));
        check_field("out_row", 64'(want.row), 64'(out_row_o));
        check_field("out_col", 64'(want.col), 64'(out_col_o));
        check_field("grid_done", 64'(want.done), 64'(grid_done_o));
        check_field("diff_sum_sq", want.sum, diff_sum_sq_o);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("[jacobi_poisson_stencil_sweep_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < COLS; i++) begin
      u_older_mem[i]  = '0;
      u_recent_mem[i] = '0;
      f_recent_mem[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_saturation();
    test_wide_grid();
    test_moved_bounds();
    test_random_sweeps();
    quiesce();

    if (mismatch_count == 0) begin
      $display("[jacobi_poisson_stencil_sweep_top] OK");
    end else begin
      $display("[jacobi_poisson_stencil_sweep_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/jps_pkg.sv
sv/jps_ram.sv
sv/jps_mul.sv
sv/jacobi_poisson_stencil_sweep_top.sv
sim/jacobi_poisson_stencil_sweep_top_test.sv
